>>> design/assert_macros.svh
// Assertion macros used by the slot allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GSA_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("gsa: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define GSA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsa: same-cycle implication violated");

// A consequence that must hold in the cycle after its trigger.
`define GSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsa: next-cycle implication violated");

`endif

>>> design/gsa_pkg.sv
// Types and constants shared by the generational slot allocator modules.
package gsa_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int GEN_W     = 16;
   localparam int LIMIT_W   = 11;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [GEN_W-1:0] gen_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // One entry of the slot table: deleted mark above the generation.
   typedef struct packed {
      logic    deleted;
      gen_type gen;
   } slot_entry_type;

   // Requests from the sequencer to the free stack.
   typedef struct packed {
      logic    push;
      logic    pop;
      idx_type push_data;
   } stack_ctl_type;

endpackage

>>> design/generational_slot_allocator_top.sv
// Top level of the generational slot allocator: sequencer, slot table and ports.
// Handle table with a generation counter per slot. Each req word carries an
// operation in req_tuser (allocate, release, query) and a handle in req_tdata;
// each accepted word yields exactly one rsp word, in order. Allocate pops the
// most recently released slot, or grows the table up to the limit written on
// the csr channel, and returns index and generation. Release retires a live
// handle and bumps its generation; query reports liveness.
// Items are handled one at a time. A grow, a full table, the unused operation
// or a handle rejected by range or generation zero go from acceptance straight
// to the result state, which loads the rsp register; a release or query that
// reads the slot table passes through the table read state first, and a reuse
// reads the free stack and then the slot table. The next word follows that load.
// The rsp register holds a result while rsp_tready is low; a new req word is
// still accepted, and its result waits until the register frees up.
// Reset (synchronous, active high) empties the free stack, clears the high
// water mark and sets the slot limit to 1024. Table and stack contents are
// left as they are; only entries written since reset are ever read. The csr
// channel is always ready, unchecked; the user writes it only while the block is idle.
`include "assert_macros.svh"

module generational_slot_allocator_top
   import gsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [9:0] handle_index, [25:10] handle_generation
   input  logic [MODE_W-1:0]  req_tuser,   // [1:0] mode
   // Response channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [9:0] slot_index, [25:10] allocated generation
   output logic [STATUS_W-1:0] rsp_tuser,  // [1:0] status
   // Slot limit register.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_TRD  = 2'd2;
   localparam logic [1:0] S_RES  = 2'd3;

   // Control state.
   logic [1:0]          state_ff, state_in;
   cnt_type             hw_ff, hw_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item being worked on and its pending result.
   logic [MODE_W-1:0]   mode_ff, mode_in;
   idx_type             idx_ff, idx_in;
   gen_type             gen_ff, gen_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   idx_type             res_idx_ff, res_idx_in;
   gen_type             res_gen_ff, res_gen_in;

   // Output register.
   logic [STATUS_W-1:0] rsp_status_ff;
   idx_type             rsp_idx_ff;
   gen_type             rsp_gen_ff;
   logic                rsp_load;

   // Slot table memory.
   slot_entry_type      slot_mem [MAX_SLOTS];
   slot_entry_type      tab_rd_ff;
   logic                tab_rd_en;
   idx_type             tab_rd_addr;
   logic                tab_wr_en;
   idx_type             tab_wr_addr;
   slot_entry_type      tab_wr_data;

   // Free stack.
   stack_ctl_type       stack_ctl;
   idx_type             pop_data;
   cnt_type             free_count;

   logic                req_fire;
   logic [MODE_W-1:0]   in_mode;
   idx_type             in_idx;
   gen_type             in_gen;
   cnt_type             eff_limit;
   logic                can_grow;
   logic                in_range;
   logic                alive;
   gen_type             next_gen;
   logic                grow_fire;
   logic                rsp_is_full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_mode = req_tuser;
   assign in_idx  = req_tdata[IDX_W-1:0];
   assign in_gen  = req_tdata[IDX_W+GEN_W-1:IDX_W];

   // A limit above the built capacity saturates to it.
   assign eff_limit = (limit_ff > LIMIT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(limit_ff);
   assign can_grow  = (hw_ff < eff_limit);
   assign in_range  = ({1'b0, in_idx} < hw_ff);

   // The stored generation is compared against the handle latched at acceptance.
   assign alive    = !tab_rd_ff.deleted && (tab_rd_ff.gen == gen_ff);
   // Generations wrap past all ones to one, never to zero.
   assign next_gen = (tab_rd_ff.gen == '1) ? GEN_W'(1) : tab_rd_ff.gen + GEN_W'(1);

   always_comb begin
      state_in      = state_ff;
      hw_in         = hw_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      gen_in        = gen_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_gen_in    = res_gen_ff;
      tab_rd_en     = 1'b0;
      tab_rd_addr   = in_idx;
      tab_wr_en     = 1'b0;
      tab_wr_addr   = idx_ff;
      tab_wr_data   = '{deleted: 1'b0, gen: tab_rd_ff.gen};
      stack_ctl     = '{push: 1'b0, pop: 1'b0, push_data: idx_ff};
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in       = in_mode;
               idx_in        = in_idx;
               gen_in        = in_gen;
               // By default a result echoes the index and reports a dead handle.
               res_status_in = STATUS_DEAD;
               res_idx_in    = in_idx;
               res_gen_in    = '0;
               state_in      = S_RES;
               unique case (in_mode) inside
                  MODE_ALLOC: begin
                     if (free_count != '0) begin
                        stack_ctl.pop = 1'b1;
                        state_in      = S_POP;
                     end else if (can_grow) begin
                        // A fresh slot starts at generation one.
                        tab_wr_en     = 1'b1;
                        tab_wr_addr   = hw_ff[IDX_W-1:0];
                        tab_wr_data   = '{deleted: 1'b0, gen: GEN_W'(1)};
                        hw_in         = hw_ff + CNT_W'(1);
                        res_status_in = STATUS_OK;
                        res_idx_in    = hw_ff[IDX_W-1:0];
                        res_gen_in    = GEN_W'(1);
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  MODE_RELEASE, MODE_QUERY: begin
                     if ((in_gen != '0) && in_range) begin
                        tab_rd_en   = 1'b1;
                        tab_rd_addr = in_idx;
                        state_in    = S_TRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            // The popped index is now on the stack read port.
            tab_rd_en   = 1'b1;
            tab_rd_addr = pop_data;
            idx_in      = pop_data;
            state_in    = S_TRD;
         end
         S_TRD: begin
            unique case (mode_ff) inside
               MODE_ALLOC: begin
                  // Reuse keeps the generation and clears the deleted mark.
                  tab_wr_en     = 1'b1;
                  tab_wr_data   = '{deleted: 1'b0, gen: tab_rd_ff.gen};
                  res_status_in = STATUS_OK;
                  res_idx_in    = idx_ff;
                  res_gen_in    = tab_rd_ff.gen;
               end
               MODE_RELEASE: begin
                  if (alive) begin
                     tab_wr_en      = 1'b1;
                     tab_wr_data    = '{deleted: 1'b1, gen: next_gen};
                     stack_ctl.push = 1'b1;
                     res_status_in  = STATUS_OK;
                  end
               end
               MODE_QUERY: begin
                  if (alive) begin
                     res_status_in = STATUS_OK;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_RES;
         end
         S_RES: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= '0;
         limit_ff     <= LIMIT_W'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      gen_ff        <= gen_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_gen_ff    <= res_gen_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_idx_ff    <= res_idx_ff;
         rsp_gen_ff    <= res_gen_ff;
      end
   end

   // Reads and writes never hit the table in the same cycle.
   always_ff @(posedge clock) begin
      if (tab_wr_en) begin
         slot_mem[tab_wr_addr] <= tab_wr_data;
      end
      if (tab_rd_en) begin
         tab_rd_ff <= slot_mem[tab_rd_addr];
      end
   end

   gsa_free_stack u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (stack_ctl),
      .pop_data (pop_data),
      .count    (free_count)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_gen_ff, rsp_idx_ff};

   assign grow_fire   = req_fire && (in_mode == MODE_ALLOC) && (free_count == '0) && can_grow;
   assign rsp_is_full = rsp_tvalid && (rsp_tuser == STATUS_FULL);

   // Every stacked slot was once grown, so the stack never outruns the high water mark.
   `GSA_ASSERT(a_free_le_hw, clock, reset, free_count <= hw_ff)
   `GSA_ASSERT(a_hw_cap, clock, reset, hw_ff <= CNT_W'(MAX_SLOTS))
   `GSA_ASSERT_IMPLY(a_full_no_gen, clock, reset, rsp_is_full, rsp_gen_ff == '0)
   `GSA_ASSERT_NEXT(a_grow_step, clock, reset, grow_fire, hw_ff == $past(hw_ff) + CNT_W'(1))

endmodule

>>> design/gsa_free_stack.sv
// LIFO stack of released slot indexes held in a synchronous memory.
module gsa_free_stack
   import gsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stack_ctl_type ctl,
   output idx_type       pop_data,
   output cnt_type       count
);

   idx_type stack_mem [MAX_SLOTS];
   cnt_type count_ff, count_in;
   idx_type pop_data_ff;
   idx_type top_addr;
   logic    not_empty;
   logic    not_full;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != CNT_W'(MAX_SLOTS));
   assign top_addr  = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      count_in = count_ff;
      if (ctl.pop && not_empty) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctl.push && not_full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A full stack drops the push; the count never lets that happen in practice.
   always_ff @(posedge clock) begin
      if (ctl.push && not_full) begin
         stack_mem[count_ff[IDX_W-1:0]] <= ctl.push_data;
      end
      if (ctl.pop) begin
         pop_data_ff <= stack_mem[top_addr];
      end
   end

   assign pop_data = pop_data_ff;
   assign count    = count_ff;

endmodule

>>> tb/sv/generational_slot_allocator_top_tb.sv
// Self-checking testbench for the generational slot allocator top level.
module generational_slot_allocator_top_tb;
   import gsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The package names three operations; the fourth encoding is unused.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Bound for the watchdog, far above the length of a correct run.
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_OPS_PER_PHASE = 150;
   // Margin beyond the longest path from acceptance to the load of the rsp register.
   localparam int SETTLE_CYCLES = 6;

   typedef logic [MODE_W-1:0] mode_bits_type;

   // One request word as the block sees it.
   typedef struct {
      mode_bits_type mode;
      idx_type       idx;
      gen_type       gen;
   } handle_op_type;

   // One response word as the block should produce it.
   typedef struct {
      logic [STATUS_W-1:0] status;
      idx_type             slot_idx;
      gen_type             slot_gen;
   } slot_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;   // [9:0] handle_index, [25:10] handle_generation
   logic [MODE_W-1:0]    req_tuser = '0;   // [1:0] mode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // [9:0] slot_index, [25:10] allocated generation
   logic [STATUS_W-1:0]  rsp_tuser;        // [1:0] status
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [LIMIT_W-1:0]   csr_data = '0;

   generational_slot_allocator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Mirror of the handle table, kept in step with every accepted request word.
   gen_type            tbl_gen [MAX_SLOTS];
   bit                 tbl_deleted [MAX_SLOTS];
   idx_type            free_list_mirror [$];  // back of the queue is the top of the stack
   int unsigned        grown = 0;             // high-water mark
   logic [LIMIT_W-1:0] limit_mirror = 11'd1024;
   idx_type            live_slots [$];        // slots handed out and not yet released

   handle_op_type   queued_ops [$];
   slot_result_type pending_results [$];
   handle_op_type   bus_op;
   bit              op_on_bus = 1'b0;
   int              gap_left = 0;
   int              stall_left = 0;
   bit              idle_on = 1'b1;
   int              error_count = 0;
   int unsigned     cycle_count = 0;

   function automatic bit handle_is_live(idx_type idx, gen_type gen);
      return gen != '0 && idx < grown && tbl_gen[idx] == gen && !tbl_deleted[idx];
   endfunction

   function automatic void drop_live_slot(idx_type idx);
      for (int i = 0; i < live_slots.size(); i++) begin
         if (live_slots[i] == idx) begin
            live_slots.delete(i);
            return;
         end
      end
   endfunction

   // Works out the response to one accepted word and advances the mirror.
   function automatic void apply_handle_op(handle_op_type op);
      slot_result_type res;
      idx_type         s;
      gen_type         next_gen;
      int unsigned     eff_limit;
      res.status   = STATUS_DEAD;
      res.slot_idx = op.idx;
      res.slot_gen = '0;
      eff_limit = (limit_mirror > MAX_SLOTS) ? MAX_SLOTS : limit_mirror;
      case (op.mode)
         MODE_ALLOC: begin
            if (free_list_mirror.size() != 0) begin
               // Reuse keeps the generation that the release left behind.
               s = free_list_mirror[$];
               free_list_mirror.delete(free_list_mirror.size() - 1);
               tbl_deleted[s] = 1'b0;
               res.status   = STATUS_OK;
               res.slot_idx = s;
               res.slot_gen = tbl_gen[s];
               live_slots = {live_slots, s};
            end else if (grown < eff_limit) begin
               s = idx_type'(grown);
               tbl_gen[s]     = gen_type'(1);
               tbl_deleted[s] = 1'b0;
               grown++;
               res.status   = STATUS_OK;
               res.slot_idx = s;
               res.slot_gen = gen_type'(1);
               live_slots = {live_slots, s};
            end else begin
               res.status = STATUS_FULL;
            end
         end
         MODE_RELEASE: begin
            if (handle_is_live(op.idx, op.gen)) begin
               // Generation zero marks a bad handle, so the count skips it.
               next_gen = tbl_gen[op.idx] + gen_type'(1);
               if (next_gen == '0)
                  next_gen = gen_type'(1);
               tbl_gen[op.idx]     = next_gen;
               tbl_deleted[op.idx] = 1'b1;
               if (free_list_mirror.size() < MAX_SLOTS)
                  free_list_mirror = {free_list_mirror, op.idx};
               drop_live_slot(op.idx);
               res.status = STATUS_OK;
            end
         end
         MODE_QUERY: begin
            if (handle_is_live(op.idx, op.gen))
               res.status = STATUS_OK;
         end
         default: ;
      endcase
      pending_results = {pending_results, res};
   endfunction

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_cycles();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   // Request driver: presents queued words and updates the mirror on each handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         op_on_bus = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_handle_op(bus_op);
            op_on_bus = 1'b0;
         end
         if (!op_on_bus) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (queued_ops.size() != 0) begin
               bus_op = queued_ops.pop_front();
               op_on_bus = 1'b1;
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, bus_op.gen, bus_op.idx};
               req_tuser  <= bus_op.mode;
               gap_left = idle_cycles();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure, and every word checked against the
   // oldest outstanding expectation.
   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: rsp word with nothing expected: status %0d index %0d gen %0d",
                        $time, rsp_tuser, rsp_tdata[9:0], rsp_tdata[25:10]);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[9:0] !== want.slot_idx) begin
                  $display("%0t: slot_index expected %0d actual %0d",
                           $time, want.slot_idx, rsp_tdata[9:0]);
                  error_count++;
               end
               if (rsp_tdata[25:10] !== want.slot_gen) begin
                  $display("%0t: generation expected %0d actual %0d",
                           $time, want.slot_gen, rsp_tdata[25:10]);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = idle_cycles();
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Keeps the word queue short so that random picks see nearly current state.
   task automatic queue_op(input mode_bits_type mode, input idx_type idx, input gen_type gen);
      handle_op_type op;
      op.mode = mode;
      op.idx  = idx;
      op.gen  = gen;
      while (queued_ops.size() >= 2)
         @(posedge clock);
      queued_ops = {queued_ops, op};
   endtask

   // The block is idle once nothing is queued, on the bus or outstanding.
   task automatic wait_for_idle();
      while (queued_ops.size() != 0 || op_on_bus || pending_results.size() != 0)
         @(posedge clock);
   endtask

   // The limit register is only written with the block idle.
   task automatic write_slot_limit(input logic [LIMIT_W-1:0] value);
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      limit_mirror = value;
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic on handles that are live now, plus stale
   // handles and raw noise over every field.
   function automatic handle_op_type pick_random_op();
      handle_op_type op;
      int            r;
      int            pick;
      op.mode = MODE_ALLOC;
      op.idx  = idx_type'($urandom);
      op.gen  = gen_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < 35) begin
         op.mode = MODE_ALLOC;
      end else if (r < 75 && live_slots.size() != 0) begin
         pick = $urandom_range(0, live_slots.size() - 1);
         op.idx  = live_slots[pick];
         op.gen  = tbl_gen[op.idx];
         op.mode = (r < 58) ? MODE_RELEASE : MODE_QUERY;
      end else if (r < 87 && grown != 0) begin
         // An old handle for a slot that exists: current or previous generation.
         op.idx  = idx_type'($urandom_range(0, grown - 1));
         op.gen  = tbl_gen[op.idx] - gen_type'($urandom_range(0, 1));
         op.mode = $urandom_range(0, 1) ? MODE_RELEASE : MODE_QUERY;
      end else begin
         op.mode = mode_bits_type'($urandom_range(0, 3));
         // Sometimes aim just past the grown region.
         if ($urandom_range(0, 3) == 0)
            op.idx = idx_type'(grown);
      end
      return op;
   endfunction

   task automatic run_random_phase(input logic [LIMIT_W-1:0] limit_value);
      handle_op_type op;
      write_slot_limit(limit_value);
      for (int k = 0; k < RANDOM_OPS_PER_PHASE; k++) begin
         // Stretches with and without idling on both sides.
         if (k % 50 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         // Halfway through, hold off until every response is back.
         if (k == RANDOM_OPS_PER_PHASE / 2)
            wait_for_idle();
         op = pick_random_op();
         queue_op(op.mode, op.idx, op.gen);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at the reset limit: an empty table, bad handles, the
      // unused operation, growth, release, reuse and stale handles.
      queue_op(MODE_QUERY, 10'd0, 16'd0);
      queue_op(MODE_RELEASE, 10'd1023, 16'd65535);
      queue_op(MODE_UNUSED, 10'd1023, 16'd65535);
      queue_op(MODE_ALLOC, 10'd1023, 16'd65535);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);
      queue_op(MODE_ALLOC, 10'd512, 16'd1);
      queue_op(MODE_QUERY, 10'd0, 16'd1);
      queue_op(MODE_QUERY, 10'd2, 16'd0);
      queue_op(MODE_QUERY, 10'd3, 16'd1);
      queue_op(MODE_RELEASE, 10'd1, 16'd1);
      queue_op(MODE_RELEASE, 10'd1, 16'd1);
      queue_op(MODE_QUERY, 10'd1, 16'd2);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);
      queue_op(MODE_QUERY, 10'd1, 16'd2);
      queue_op(MODE_QUERY, 10'd1, 16'd1);

      // A zero limit forbids growth, but the free stack still serves.
      write_slot_limit(11'd0);
      queue_op(MODE_ALLOC, 10'h2AA, 16'd0);
      queue_op(MODE_RELEASE, 10'd0, 16'd1);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);
      queue_op(MODE_ALLOC, 10'h155, 16'hFFFF);

      // The largest value saturates to the built capacity.
      write_slot_limit(11'd2047);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);

      // A limit below the high-water mark keeps existing slots usable.
      write_slot_limit(11'd1);
      queue_op(MODE_ALLOC, 10'd7, 16'd0);
      queue_op(MODE_RELEASE, 10'd2, 16'd1);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);
      queue_op(MODE_ALLOC, 10'd0, 16'd0);

      // Random traffic under a range of limits.
      run_random_phase(11'd6);
      run_random_phase(11'd0);
      run_random_phase(11'd40);
      run_random_phase(11'd2047);
      run_random_phase(11'd1024);

      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
